/* hdl/edd_pkg.sv */
package edd_pkg;

  localparam int OUT_W = 7;
  localparam logic [OUT_W-1:0] DIST_MAX = 7'd127;

  localparam logic [1:0] OP_FIRST   = 2'd0;
  localparam logic [1:0] OP_SECOND  = 2'd1;
  localparam logic [1:0] OP_COMPUTE = 2'd2;

  typedef struct packed {
    logic load_first;
    logic load_second;
    logic begin_sweep;
    logic finish_empty;
    logic fetch;
    logic cost_step;
  } edd_cmd_t;

  typedef struct packed {
    logic empty;
    logic row_end;
    logic last_row;
  } edd_status_t;

endpackage

/* hdl/levenshtein_edit_distance.sv */
// Levenshtein distance engine. Each string is loaded one symbol per
// transaction (op 0 or 1), and busy stays low during an append. A compute
// transaction (op 2) with strings of lengths M and N, both non-zero, holds
// busy high while the cost-row memory sweeps one table cell per cycle
// within a row, with a fetch step before each row for the row's symbol.
// The result strobe, out_valid, is high for one cycle, the first cycle in
// which busy is low again; the receiver cannot stall it, so it must take
// the result then. If either string is empty the result appears in the
// cycle after the compute transaction. Symbols appended beyond MAX_LEN are
// dropped and flagged on out_overflow. Distances above 127 read as 127.
module levenshtein_edit_distance
  import edd_pkg::*;
#(
  parameter int MAX_LEN = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       in_op,
  input  logic [7:0]       in_symbol,
  output logic             out_valid,
  output logic [OUT_W-1:0] out_distance,
  output logic             out_overflow
);

  edd_cmd_t    cmd;
  edd_status_t status;

  edd_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .op     (in_op),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  edd_datapath #(.MAX_LEN(MAX_LEN)) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .symbol       (in_symbol),
    .status       (status),
    .out_valid    (out_valid),
    .out_distance (out_distance),
    .out_overflow (out_overflow)
  );

endmodule

/* hdl/edd_ram.sv */
module edd_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hdl/edd_ctrl.sv */
module edd_ctrl
  import edd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [1:0]  op,
  input  edd_status_t status,
  output edd_cmd_t    cmd,
  output logic        busy
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FETCH = 2'd1;
  localparam logic [1:0] S_RUN   = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (op)
            OP_FIRST:  cmd.load_first  = 1'b1;
            OP_SECOND: cmd.load_second = 1'b1;
            OP_COMPUTE: begin
              cmd.begin_sweep = 1'b1;
              if (status.empty) begin
                cmd.finish_empty = 1'b1;
              end else begin
                state_nxt = S_FETCH;
              end
            end
            default: ;
          endcase
        end
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = S_RUN;
      end
      S_RUN: begin
        cmd.cost_step = 1'b1;
        if (status.row_end) begin
          state_nxt = status.last_row ? S_IDLE : S_FETCH;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

/* hdl/edd_datapath.sv */
module edd_datapath
  import edd_pkg::*;
#(
  parameter int MAX_LEN = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  edd_cmd_t         cmd,
  input  logic [7:0]       symbol,
  output edd_status_t      status,
  output logic             out_valid,
  output logic [OUT_W-1:0] out_distance,
  output logic             out_overflow
);

  localparam int CNTW = $clog2(MAX_LEN + 1);
  localparam int AW   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int XW   = (CNTW > OUT_W) ? CNTW : OUT_W;

  logic [CNTW-1:0]  first_count_r, second_count_r;
  logic             overflow_r;
  logic [CNTW-1:0]  row_r, col_r;
  logic [CNTW-1:0]  corner_r, left_r;
  logic             first_row_r;
  logic             out_valid_r;
  logic [OUT_W-1:0] out_distance_r;
  logic             out_overflow_r;

  logic             first_full, second_full;
  logic             first_wr, second_wr;
  logic             second_rd;
  logic [AW-1:0]    second_rd_addr;
  logic             cost_rd;
  logic [CNTW-1:0]  cost_rd_addr;
  logic [7:0]       first_sym, second_sym;
  logic [CNTW-1:0]  cost_above_mem;
  logic [CNTW-1:0]  above;
  logic [CNTW:0]    via_above, via_left, via_change, best_ab, best;
  logic [CNTW-1:0]  cell_cost;
  logic [CNTW-1:0]  empty_dist;
  logic [CNTW-1:0]  final_dist;
  logic [XW-1:0]    final_wide;
  logic             sweep_done;
  logic             finish;

  assign first_full  = (first_count_r == CNTW'(MAX_LEN));
  assign second_full = (second_count_r == CNTW'(MAX_LEN));
  assign first_wr    = cmd.load_first && !first_full;
  assign second_wr   = cmd.load_second && !second_full;

  assign status.empty    = (first_count_r == '0) || (second_count_r == '0);
  assign status.row_end  = (col_r == second_count_r);
  assign status.last_row = (row_r == first_count_r);

  // Reads for the next cell are issued while the current cell is computed,
  // so one cell completes every cycle within a row.
  assign second_rd      = cmd.fetch || (cmd.cost_step && !status.row_end);
  assign second_rd_addr = cmd.fetch ? '0 : col_r[AW-1:0];
  assign cost_rd        = second_rd;
  assign cost_rd_addr   = cmd.fetch ? CNTW'(1) : CNTW'(col_r + CNTW'(1));

  edd_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_first_text (
    .clk     (clk),
    .wr_en   (first_wr),
    .wr_addr (first_count_r[AW-1:0]),
    .wr_data (symbol),
    .rd_en   (cmd.fetch),
    .rd_addr (AW'(row_r - CNTW'(1))),
    .rd_data (first_sym)
  );

  edd_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_second_text (
    .clk     (clk),
    .wr_en   (second_wr),
    .wr_addr (second_count_r[AW-1:0]),
    .wr_data (symbol),
    .rd_en   (second_rd),
    .rd_addr (second_rd_addr),
    .rd_data (second_sym)
  );

  edd_ram #(.WIDTH(CNTW), .DEPTH(MAX_LEN + 1)) u_cost_row (
    .clk     (clk),
    .wr_en   (cmd.cost_step),
    .wr_addr (col_r),
    .wr_data (cell_cost),
    .rd_en   (cost_rd),
    .rd_addr (cost_rd_addr),
    .rd_data (cost_above_mem)
  );

  // The top row of the table is simply the column index, so it is never
  // stored and the first sweep row takes it directly.
  assign above      = first_row_r ? col_r : cost_above_mem;
  assign via_above  = {1'b0, above} + (CNTW+1)'(1);
  assign via_left   = {1'b0, left_r} + (CNTW+1)'(1);
  assign via_change = {1'b0, corner_r} + {{CNTW{1'b0}}, (first_sym != second_sym)};
  assign best_ab    = (via_above < via_left) ? via_above : via_left;
  assign best       = (best_ab < via_change) ? best_ab : via_change;
  assign cell_cost  = best[CNTW-1:0];

  assign sweep_done = cmd.cost_step && status.row_end && status.last_row;
  assign finish     = cmd.finish_empty || sweep_done;
  assign empty_dist = (first_count_r == '0) ? second_count_r : first_count_r;
  assign final_dist = cmd.finish_empty ? empty_dist : cell_cost;
  assign final_wide = XW'(final_dist);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_count_r  <= '0;
      second_count_r <= '0;
      overflow_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      out_valid_r <= finish;
      if (finish) begin
        first_count_r  <= '0;
        second_count_r <= '0;
        overflow_r     <= 1'b0;
      end else begin
        if (first_wr) begin
          first_count_r <= first_count_r + CNTW'(1);
        end
        if (second_wr) begin
          second_count_r <= second_count_r + CNTW'(1);
        end
        if ((cmd.load_first && first_full) || (cmd.load_second && second_full)) begin
          overflow_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.begin_sweep) begin
      row_r       <= CNTW'(1);
      first_row_r <= 1'b1;
    end
    if (cmd.fetch) begin
      col_r    <= CNTW'(1);
      corner_r <= row_r - CNTW'(1);
      left_r   <= row_r;
    end
    if (cmd.cost_step) begin
      col_r    <= col_r + CNTW'(1);
      corner_r <= above;
      left_r   <= cell_cost;
      if (status.row_end) begin
        row_r       <= row_r + CNTW'(1);
        first_row_r <= 1'b0;
      end
    end
    if (finish) begin
      out_distance_r <= (final_wide > XW'(DIST_MAX)) ? DIST_MAX : final_wide[OUT_W-1:0];
      out_overflow_r <= overflow_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_distance = out_distance_r;
  assign out_overflow = out_overflow_r;

endmodule

/* sim/edd_score_pkg.sv */
package edd_score_pkg;
  import edd_pkg::*;

  localparam int TEXT_DEPTH = 64;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [OUT_W-1:0] distance;
    logic             overflow;
  } edit_answer_t;

  // Tracks both loaded strings and holds the distances still owed by the block.
  class edit_distance_board;
    logic [7:0]   first_text[TEXT_DEPTH];
    logic [7:0]   second_text[TEXT_DEPTH];
    int           first_len;
    int           second_len;
    bit           dropped;
    edit_answer_t pending_answers[$];
    int           errors;
    int           answers_checked;
    int           truncated_answers;
    int           widest_distance;

    function new();
      first_len = 0;
      second_len = 0;
      dropped = 1'b0;
      errors = 0;
      answers_checked = 0;
      truncated_answers = 0;
      widest_distance = 0;
    endfunction

    // Single cost row, swept one table cell at a time.
    function int sweep_cost();
      int row[TEXT_DEPTH+1];
      int corner;
      int above;
      int change;
      int low;
      for (int j = 0; j <= second_len; j++) row[j] = j;
      for (int i = 1; i <= first_len; i++) begin
        corner = row[0];
        row[0] = i;
        for (int j = 1; j <= second_len; j++) begin
          above = row[j];
          change = corner + ((first_text[i-1] == second_text[j-1]) ? 0 : 1);
          low = (above + 1 < row[j-1] + 1) ? above + 1 : row[j-1] + 1;
          row[j] = (low < change) ? low : change;
          corner = above;
        end
      end
      return row[second_len];
    endfunction

    function void note_transaction(logic [1:0] op, logic [7:0] sym);
      edit_answer_t answer;
      int cost;
      case (op)
        OP_FIRST: begin
          if (first_len >= TEXT_DEPTH) dropped = 1'b1;
          else begin
            first_text[first_len] = sym;
            first_len++;
          end
        end
        OP_SECOND: begin
          if (second_len >= TEXT_DEPTH) dropped = 1'b1;
          else begin
            second_text[second_len] = sym;
            second_len++;
          end
        end
        OP_COMPUTE: begin
          cost = sweep_cost();
          if (cost > int'(DIST_MAX)) cost = int'(DIST_MAX);
          answer.distance = cost[OUT_W-1:0];
          answer.overflow = dropped;
          pending_answers.push_back(answer);
          first_len = 0;
          second_len = 0;
          dropped = 1'b0;
        end
        default: begin
        end
      endcase
    endfunction

    function void check_answer(logic [OUT_W-1:0] distance, logic overflow);
      edit_answer_t want;
      if (pending_answers.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: result with none outstanding: distance %0d overflow %0b",
                   $time, distance, overflow);
      end else begin
        want = pending_answers.pop_front();
        answers_checked++;
        if (want.overflow) truncated_answers++;
        if (int'(want.distance) > widest_distance) widest_distance = int'(want.distance);
        if (distance !== want.distance || overflow !== want.overflow) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("%0t: distance %0d overflow %0b, expected distance %0d overflow %0b",
                     $time, distance, overflow, want.distance, want.overflow);
        end
      end
    endfunction
  endclass

endpackage

/* sim/levenshtein_edit_distance_tb.sv */
module levenshtein_edit_distance_tb;
  import edd_pkg::*;
  import edd_score_pkg::*;

  localparam logic [1:0] OP_NOP = 2'd3;
  localparam int SETTLE_CYCLES = 16;

  typedef enum int {PAIR_RANDOM, PAIR_NARROW, PAIR_EDITED, PAIR_DISJOINT} pair_style_t;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [1:0]       in_op;
  logic [7:0]       in_symbol;
  logic             out_valid;
  logic [OUT_W-1:0] out_distance;
  logic             out_overflow;

  edit_distance_board board = new();
  int idle_pct;
  int items_sent;
  int nops_sent;

  levenshtein_edit_distance #(
    .MAX_LEN(TEXT_DEPTH)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_op       (in_op),
    .in_symbol   (in_symbol),
    .out_valid   (out_valid),
    .out_distance(out_distance),
    .out_overflow(out_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[levenshtein_edit_distance] ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) board.check_answer(out_distance, out_overflow);
  end

  // Idle cycles before a transaction; the fields carry junk while start is low.
  task automatic pace();
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      in_op <= 2'($urandom);
      in_symbol <= 8'($urandom);
    end
  endtask

  task automatic send_item(input logic [1:0] op, input logic [7:0] sym);
    pace();
    @(negedge clk);
    start <= 1'b1;
    in_op <= op;
    in_symbol <= sym;
    do @(posedge clk); while (busy);
    board.note_transaction(op, sym);
    if (op == OP_NOP) nops_sent++;
    else items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (board.pending_answers.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_symbol(input pair_style_t style);
    logic [1:0] k;
    k = 2'($urandom);
    if (style == PAIR_NARROW) return {4{k}};
    return 8'($urandom);
  endfunction

  // Loads a pair of strings, interleaving the two streams, and asks for the distance.
  task automatic run_pair(input int first_n, input int second_n, input pair_style_t style);
    logic [7:0] first_q[$];
    logic [7:0] second_q[$];
    int pos;
    int edits;
    for (int i = 0; i < first_n; i++)
      first_q.push_back(style == PAIR_DISJOINT ? 8'h00 : pick_symbol(style));
    if (style == PAIR_EDITED) begin
      second_q = first_q;
      edits = $urandom_range(0, 4);
      repeat (edits) begin
        pos = $urandom_range(0, second_q.size());
        case ($urandom_range(0, 2))
          0: second_q.insert(pos, pick_symbol(style));
          1: if (pos < second_q.size()) second_q.delete(pos);
          default: if (pos < second_q.size()) second_q[pos] = pick_symbol(style);
        endcase
      end
    end else begin
      for (int i = 0; i < second_n; i++)
        second_q.push_back(style == PAIR_DISJOINT ? 8'hFF : pick_symbol(style));
    end
    while (first_q.size() != 0 || second_q.size() != 0) begin
      if ($urandom_range(99) < 4) send_item(OP_NOP, 8'($urandom));
      if (second_q.size() == 0 || (first_q.size() != 0 && $urandom_range(1) == 1))
        send_item(OP_FIRST, first_q.pop_front());
      else
        send_item(OP_SECOND, second_q.pop_front());
    end
    send_item(OP_COMPUTE, 8'($urandom));
    // A second compute straight after finds both strings empty.
    if ($urandom_range(99) < 8) send_item(OP_COMPUTE, 8'($urandom));
  endtask

  function automatic int pick_length();
    if ($urandom_range(99) < 4) return $urandom_range(56, 70);
    return $urandom_range(0, 12);
  endfunction

  initial begin
    int target;
    pair_style_t style;
    rst_n = 1'b0;
    start = 1'b0;
    in_op = OP_FIRST;
    in_symbol = 8'h00;
    idle_pct = 0;
    items_sent = 0;
    nops_sent = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty strings, one-sided strings, extreme symbols and the unused opcode.
    send_item(OP_COMPUTE, 8'hFF);
    send_item(OP_NOP, 8'hFF);
    send_item(OP_FIRST, 8'h00);
    send_item(OP_COMPUTE, 8'h00);
    send_item(OP_SECOND, 8'hFF);
    send_item(OP_COMPUTE, 8'h00);
    send_item(OP_FIRST, 8'h00);
    send_item(OP_SECOND, 8'h00);
    send_item(OP_COMPUTE, 8'h00);
    send_item(OP_FIRST, 8'hFF);
    send_item(OP_SECOND, 8'h00);
    send_item(OP_COMPUTE, 8'hFF);
    send_item(OP_FIRST, 8'hA5);
    send_item(OP_FIRST, 8'h5A);
    send_item(OP_SECOND, 8'h5A);
    send_item(OP_NOP, 8'h00);
    send_item(OP_COMPUTE, 8'h00);
    send_item(OP_FIRST, 8'h12);
    send_item(OP_FIRST, 8'h34);
    send_item(OP_FIRST, 8'h56);
    send_item(OP_SECOND, 8'h34);
    send_item(OP_SECOND, 8'h56);
    send_item(OP_SECOND, 8'h78);
    send_item(OP_COMPUTE, 8'h00);
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 19 : (phase == 1) ? 86 : 0;
      target = 550 * (phase + 1);
      case (phase)
        0: begin
          run_pair(TEXT_DEPTH, TEXT_DEPTH, PAIR_DISJOINT);
          run_pair(TEXT_DEPTH + 2, TEXT_DEPTH + 1, PAIR_RANDOM);
        end
        1: run_pair(TEXT_DEPTH + 3, 0, PAIR_NARROW);
        default: run_pair(TEXT_DEPTH, 0, PAIR_EDITED);
      endcase
      while (items_sent < target) begin
        style = pair_style_t'($urandom_range(0, 2));
        run_pair(pick_length(), pick_length(), style);
      end
      // Hold the sender off until every outstanding distance is back.
      wait_drained();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d symbol and compute transactions plus %0d no-ops.",
             items_sent, nops_sent);
    $display("Checked %0d distances, %0d with truncated input, largest distance %0d.",
             board.answers_checked, board.truncated_answers, board.widest_distance);
    if (board.errors == 0) begin
      $display("[levenshtein_edit_distance] OK");
    end else begin
      $display("%0d mismatches in total.", board.errors);
      $display("[levenshtein_edit_distance] ERROR");
    end
    $finish;
  end

endmodule
